>>> src/base32_stream_encoder_macros.svh
// Assertion macros shared by the base32 stream encoder RTL.
`ifndef BASE32_STREAM_ENCODER_MACROS_SVH
`define BASE32_STREAM_ENCODER_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define B32_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define B32_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the following cycle.
`define B32_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/b32enc_pkg.sv
// Types, constants and the alphabet function of the base32 stream encoder.
package b32enc_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam logic [7:0] PAD_CHAR = 8'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       out_last;
   } rsp_type;

   // One byte's worth of characters: up to three slices, then pad characters.
   typedef struct packed {
      logic [2:0][4:0] slices;
      logic [1:0]      num_slices;
      logic [2:0]      last_idx;
      logic            is_final;
   } job_type;

   // A-Z then a-f
   function automatic logic [7:0] b32_char(input logic [4:0] slice);
      if (slice < 5'd26) begin
         return 8'h41 + {3'b000, slice};
      end else begin
         return 8'h61 + {3'b000, slice} - 8'd26;
      end
   endfunction

endpackage

>>> src/b32enc_front.sv
// Front end: takes source bytes, cuts them into 5-bit slices and builds jobs.
module b32enc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  b32enc_pkg::req_type req_data,
   input  logic                queue_full,
   output logic                job_push,
   output b32enc_pkg::job_type job_data
);
   import b32enc_pkg::*;
   `include "base32_stream_encoder_macros.svh"

   localparam logic [2:0] POS_0 = 3'd0;
   localparam logic [2:0] POS_1 = 3'd1;
   localparam logic [2:0] POS_2 = 3'd2;
   localparam logic [2:0] POS_3 = 3'd3;
   localparam logic [2:0] POS_4 = 3'd4;

   logic [3:0] carry_ff, carry_in;
   logic [2:0] pos_ff, pos_in;

   logic [7:0] b;
   logic [3:0] c;
   logic [4:0] s0, s1, flush;
   logic       two, has_flush;
   logic [2:0] pads;
   logic [3:0] carry_next;
   logic [2:0] pos_next;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign job_push  = accept;
   assign b         = req_data.data_byte;
   assign c         = carry_ff;

   always_comb begin
      s1        = 5'd0;
      two       = 1'b0;
      has_flush = 1'b1;
      unique case (pos_ff)
         POS_1: begin
            s0         = {c[2:0], b[7:6]};
            s1         = b[5:1];
            two        = 1'b1;
            carry_next = {3'b000, b[0]};
            flush      = {b[0], 4'b0000};
            pads       = 3'd4;
            pos_next   = POS_2;
         end
         POS_2: begin
            s0         = {c[0], b[7:4]};
            carry_next = b[3:0];
            flush      = {b[3:0], 1'b0};
            pads       = 3'd3;
            pos_next   = POS_3;
         end
         POS_3: begin
            s0         = {c[3:0], b[7]};
            s1         = b[6:2];
            two        = 1'b1;
            carry_next = {2'b00, b[1:0]};
            flush      = {b[1:0], 3'b000};
            pads       = 3'd1;
            pos_next   = POS_4;
         end
         POS_4: begin
            s0         = {c[1:0], b[7:5]};
            s1         = b[4:0];
            two        = 1'b1;
            carry_next = 4'd0;
            flush      = 5'd0;
            has_flush  = 1'b0;
            pads       = 3'd0;
            pos_next   = POS_0;
         end
         default: begin
            // start of group; unused codes behave the same
            s0         = b[7:3];
            carry_next = {1'b0, b[2:0]};
            flush      = {b[2:0], 2'b00};
            pads       = 3'd6;
            pos_next   = POS_1;
         end
      endcase
   end

   always_comb begin
      job_data.slices[0] = s0;
      job_data.slices[1] = two ? s1 : flush;
      job_data.slices[2] = flush;
      job_data.is_final  = req_data.is_final;
      if (req_data.is_final) begin
         job_data.num_slices = {1'b0, two} + 2'd1 + {1'b0, has_flush};
         job_data.last_idx   = {2'b00, two} + {2'b00, has_flush} + pads;
      end else begin
         job_data.num_slices = {1'b0, two} + 2'd1;
         job_data.last_idx   = {2'b00, two};
      end
   end

   always_comb begin
      carry_in = carry_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (req_data.is_final) begin
            carry_in = 4'd0;
            pos_in   = POS_0;
         end else begin
            carry_in = carry_next;
            pos_in   = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= 4'd0;
         pos_ff   <= POS_0;
      end else begin
         carry_ff <= carry_in;
         pos_ff   <= pos_in;
      end
   end

   `B32_ASSERT_ALWAYS(a_pos_range, clock, reset, pos_ff <= POS_4, "group position out of range")
   `B32_ASSERT_NEXT(a_final_clears, clock, reset, accept && req_data.is_final,
      pos_ff == POS_0 && carry_ff == 4'd0, "state not cleared after final byte")

endmodule

>>> src/b32enc_queue.sv
// Short job queue between the front end and the character emitter.
module b32enc_queue #(
   parameter int DEPTH = b32enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b32enc_pkg::job_type push_data,
   input  logic                pop,
   output b32enc_pkg::job_type head_data,
   output logic                empty,
   output logic                full
);
   import b32enc_pkg::*;
   `include "base32_stream_encoder_macros.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign empty     = (count_ff == CNT_W'(0));
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `B32_ASSERT_SAME(a_no_overflow, clock, reset, push, !full || pop, "push into full queue")
   `B32_ASSERT_SAME(a_no_underflow, clock, reset, pop, !empty, "pop from empty queue")

endmodule

>>> src/b32enc_back.sv
// Back end: walks each job and sends one character per transfer.
module b32enc_back (
   input  logic                clock,
   input  logic                reset,
   input  b32enc_pkg::job_type head_data,
   input  logic                queue_empty,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b32enc_pkg::rsp_type rsp_data
);
   import b32enc_pkg::*;
   `include "base32_stream_encoder_macros.svh"

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    data_ff, data_in;
   logic       load, at_end;
   logic [4:0] slice;

   assign load    = (!valid_ff || !rsp_stall) && !queue_empty;
   assign at_end  = (idx_ff == head_data.last_idx);
   assign job_pop = load && at_end;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      unique case (idx_ff[1:0])
         2'd0:    slice = head_data.slices[0];
         2'd1:    slice = head_data.slices[1];
         default: slice = head_data.slices[2];
      endcase
   end

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in.out_char = (idx_ff < {1'b0, head_data.num_slices}) ? b32_char(slice)
                                                                     : PAD_CHAR;
         data_in.out_last = head_data.is_final && at_end;
         idx_in   = at_end ? 3'd0 : idx_ff + 3'd1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   `B32_ASSERT_SAME(a_mid_job_queued, clock, reset, idx_ff != 3'd0, !queue_empty,
      "job left the queue before its last character")

endmodule

>>> src/base32_stream_encoder.sv
// Top level of the streaming base32 encoder with '=' padding.
//
//   port group   dir  handshake             payload
//   req_         in   req_valid/req_stall   req_data (data_byte, is_final)
//   rsp_         out  rsp_valid/rsp_stall   rsp_data (out_char, out_last)
//
// A byte is taken in the cycle it arrives while the job queue has room; it
// yields 1 to 8 characters, sent from a registered output one per cycle while
// rsp_stall is low. Sustained rate is set by the emitter: 1.6 characters per
// byte on average and 8 characters for a final byte at group start.
// Synchronous active-high reset clears position, carry, queue and output valid.
// A stall on rsp_ backs up through the queue into req_stall.
module base32_stream_encoder #(
   parameter int QUEUE_DEPTH = b32enc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  b32enc_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output b32enc_pkg::rsp_type rsp_data
);
   import b32enc_pkg::*;

   job_type push_data, head_data;
   logic    push, pop, q_empty, q_full;

   b32enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (q_full),
      .job_push   (push),
      .job_data   (push_data)
   );

   b32enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   b32enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_data   (head_data),
      .queue_empty (q_empty),
      .job_pop     (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
